@@ hdl/rvkc_pkg.sv @@
// ----------------------------------------------------------------------------
// rvkc_pkg: shared types and constants for the volume knob controller
// Remote code values, display codes, register indexes and widths used by
// the command, display-timer and top-level modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rvkc_pkg;

   // Motor steps per knob division
   localparam int STEPS_PER_DIVISION = 128;

   // Field widths
   localparam int VOL_W    = 6;
   localparam int DIV_W    = VOL_W + 1;   // power_divisions + volume
   localparam int STEPS_W  = 14;
   localparam int PROD_W   = DIV_W + 9;   // room for up to 511 steps per division
   localparam int TIMER_W  = 17;
   localparam int PHASES_W = 11;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 16;

   localparam logic [STEPS_W-1:0]  STEPS_MAX  = '1;
   localparam logic [TIMER_W-1:0]  TIMER_MAX  = '1;
   localparam logic [PHASES_W-1:0] PHASES_MAX = '1;

   // Remote codes
   localparam logic [31:0] CODE_VOL_UP   = 32'hE0E0E01F;
   localparam logic [31:0] CODE_VOL_DOWN = 32'hE0E0D02F;
   localparam logic [31:0] CODE_MUTE     = 32'hE0E0F00F;
   localparam logic [31:0] CODE_POWER    = 32'hE0E036C9;
   localparam logic [31:0] CODE_RAW_UP   = 32'hE0E028D7;
   localparam logic [31:0] CODE_RAW_DOWN = 32'hE0E0A857;
   localparam logic [31:0] CODE_RESET    = 32'hE0E06897;

   // Display action codes
   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_SHOW = 2'd1,
      ACT_LOGO = 2'd2,
      ACT_OFF  = 2'd3
   } action_type;

   // Display content kind
   typedef enum logic [1:0] {
      KIND_OFF  = 2'd0,
      KIND_ZERO = 2'd1,
      KIND_MAX  = 2'd2,
      KIND_NUM  = 2'd3
   } kind_type;

   // Burn-in phase index values
   localparam logic [1:0] PHASE_LOGO  = 2'd0;
   localparam logic [1:0] PHASE_STATE = 2'd2;

   // Register indexes
   typedef enum logic [CSR_AW-1:0] {
      CSR_TICK_PERIOD = 3'd0,
      CSR_IDLE_THRESH = 3'd1,
      CSR_PHASE_LEN   = 3'd2,
      CSR_PHASE_LIMIT = 3'd3,
      CSR_VOL_CEILING = 3'd4,
      CSR_POWER_DIVS  = 3'd5
   } csr_idx_type;

   // Configuration register set
   typedef struct packed {
      logic [9:0]       tick_period_ms;
      logic [15:0]      idle_threshold_ms;
      logic [15:0]      phase_length_ms;
      logic [9:0]       phase_limit;
      logic [VOL_W-1:0] volume_ceiling;
      logic [VOL_W-1:0] power_divisions;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      tick_period_ms:    10'd300,
      idle_threshold_ms: 16'd5000,
      phase_length_ms:   16'd5000,
      phase_limit:       10'd180,
      volume_ceiling:    6'd40,
      power_divisions:   6'd6
   };

   // Stepper move command
   typedef struct packed {
      logic               valid;
      logic               clockwise;
      logic [STEPS_W-1:0] steps;
   } move_type;

   // Knob state after a request
   typedef struct packed {
      kind_type         kind;
      logic [VOL_W-1:0] volume;
      logic             powered;
      logic             muted;
   } status_type;

endpackage

`default_nettype wire

@@ hdl/rvkc_cmd.sv @@
// ----------------------------------------------------------------------------
// rvkc_cmd: remote code decoder and knob state
// Decodes the remote code of a request, updates power, mute and volume and
// forms the stepper move and the display kind of the new state.
// ----------------------------------------------------------------------------
`default_nettype none

module rvkc_cmd (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            fire,
   input  wire logic                            code_valid,
   input  wire logic [31:0]                     ir_code,
   input  wire logic [rvkc_pkg::VOL_W-1:0]      volume_ceiling,
   input  wire logic [rvkc_pkg::VOL_W-1:0]      power_divisions,
   output rvkc_pkg::move_type                   move_o,
   output rvkc_pkg::status_type                 status_o
);

   logic                         powered_ff, powered_in;
   logic                         muted_ff, muted_in;
   logic [rvkc_pkg::VOL_W-1:0]   volume_ff, volume_in;
   logic [rvkc_pkg::DIV_W-1:0]   divs;
   logic [rvkc_pkg::PROD_W-1:0]  prod;
   logic                         mv, cw;

   // Command decode and next state
   always_comb begin
      powered_in = powered_ff;
      muted_in   = muted_ff;
      volume_in  = volume_ff;
      mv         = 1'b0;
      cw         = 1'b0;
      divs       = '0;
      if (code_valid) begin
         case (ir_code)
            rvkc_pkg::CODE_VOL_UP: begin
               if (powered_ff && !muted_ff && (volume_ff < volume_ceiling)) begin
                  mv        = 1'b1;
                  divs      = rvkc_pkg::DIV_W'(1);
                  volume_in = volume_ff + rvkc_pkg::VOL_W'(1);
               end
            end
            rvkc_pkg::CODE_VOL_DOWN: begin
               if (powered_ff && !muted_ff && (volume_ff != '0)) begin
                  mv        = 1'b1;
                  cw        = 1'b1;
                  divs      = rvkc_pkg::DIV_W'(1);
                  volume_in = volume_ff - rvkc_pkg::VOL_W'(1);
               end
            end
            rvkc_pkg::CODE_MUTE: begin
               if (powered_ff && (volume_ff != '0)) begin
                  mv       = 1'b1;
                  cw       = !muted_ff;
                  divs     = rvkc_pkg::DIV_W'(volume_ff);
                  muted_in = !muted_ff;
               end
            end
            rvkc_pkg::CODE_POWER: begin
               mv         = 1'b1;
               cw         = powered_ff;
               divs       = rvkc_pkg::DIV_W'(power_divisions)
                          + (muted_ff ? '0 : rvkc_pkg::DIV_W'(volume_ff));
               powered_in = !powered_ff;
            end
            rvkc_pkg::CODE_RAW_UP: begin
               mv   = 1'b1;
               divs = rvkc_pkg::DIV_W'(1);
            end
            rvkc_pkg::CODE_RAW_DOWN: begin
               mv   = 1'b1;
               cw   = 1'b1;
               divs = rvkc_pkg::DIV_W'(1);
            end
            rvkc_pkg::CODE_RESET: begin
               powered_in = 1'b0;
               muted_in   = 1'b0;
               volume_in  = '0;
            end
            default: ;
         endcase
      end
   end

   // Divisions to motor steps, saturated
   assign prod = rvkc_pkg::PROD_W'(divs)
               * rvkc_pkg::PROD_W'(rvkc_pkg::STEPS_PER_DIVISION);

   always_comb begin
      move_o.valid     = mv;
      move_o.clockwise = cw;
      if (prod > rvkc_pkg::PROD_W'(rvkc_pkg::STEPS_MAX)) begin
         move_o.steps = rvkc_pkg::STEPS_MAX;
      end else begin
         move_o.steps = prod[rvkc_pkg::STEPS_W-1:0];
      end
   end

   // Display kind of the new state
   always_comb begin
      status_o.volume  = volume_in;
      status_o.powered = powered_in;
      status_o.muted   = muted_in;
      if (!powered_in) begin
         status_o.kind = rvkc_pkg::KIND_OFF;
      end else if (muted_in || (volume_in == '0)) begin
         status_o.kind = rvkc_pkg::KIND_ZERO;
      end else if (volume_in == volume_ceiling) begin
         status_o.kind = rvkc_pkg::KIND_MAX;
      end else begin
         status_o.kind = rvkc_pkg::KIND_NUM;
      end
   end

   // Knob state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         powered_ff <= 1'b0;
         muted_ff   <= 1'b0;
         volume_ff  <= '0;
      end else if (fire) begin
         powered_ff <= powered_in;
         muted_ff   <= muted_in;
         volume_ff  <= volume_in;
      end
   end

   // State only moves on a processed request carrying a code
   a_no_code_hold: assert property (@(posedge clock) disable iff (reset)
      fire && !code_valid |=> $stable(volume_ff) && $stable(powered_ff) && $stable(muted_ff))
      else $error("knob state changed without a code");

   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(volume_ff) && $stable(muted_ff))
      else $error("knob state changed without a request");

   a_no_move_zero: assert property (@(posedge clock) disable iff (reset)
      !move_o.valid |-> (move_o.steps == '0) && !move_o.clockwise)
      else $error("move fields set without a move");

endmodule

`default_nettype wire

@@ hdl/rvkc_burnin.sv @@
// ----------------------------------------------------------------------------
// rvkc_burnin: idle and burn-in display timers
// Tracks idle time since the last code, then steps the display through
// logo, off, state and off phases until the phase limit holds it off.
// ----------------------------------------------------------------------------
`default_nettype none

module rvkc_burnin (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire logic                 code_valid,
   input  wire rvkc_pkg::cfg_type    cfg,
   output rvkc_pkg::action_type      action_o
);

   localparam int SUM_W = rvkc_pkg::TIMER_W + 1;
   localparam logic [1:0] PHASE_RESET_IDX = rvkc_pkg::PHASE_LOGO;

   logic                            cycling_ff, cycling_in;
   logic [rvkc_pkg::TIMER_W-1:0]    idle_ff, idle_in;
   logic [rvkc_pkg::TIMER_W-1:0]    phase_timer_ff, phase_timer_in;
   logic [1:0]                      phase_idx_ff, phase_idx_in;
   logic [rvkc_pkg::PHASES_W-1:0]   phases_ff, phases_in;
   logic                            cycling_now;
   logic [rvkc_pkg::TIMER_W-1:0]    idle_base, phase_base;
   logic [SUM_W-1:0]                idle_sum, phase_sum;
   logic [rvkc_pkg::TIMER_W-1:0]    idle_sat;

   // A code ends cycling and restarts the idle timer
   assign cycling_now = code_valid ? 1'b0 : cycling_ff;
   assign idle_base   = code_valid ? '0 : idle_ff;

   assign idle_sum = SUM_W'(idle_base) + SUM_W'(cfg.tick_period_ms);
   assign idle_sat = (idle_sum > SUM_W'(rvkc_pkg::TIMER_MAX)) ? rvkc_pkg::TIMER_MAX
                   : idle_sum[rvkc_pkg::TIMER_W-1:0];

   // Phase timer restarts when a phase ends
   always_comb begin
      phase_base = phase_timer_ff;
      if ((phases_ff <= rvkc_pkg::PHASES_W'(cfg.phase_limit)) &&
          (phase_timer_ff >= rvkc_pkg::TIMER_W'(cfg.phase_length_ms))) begin
         phase_base = '0;
      end
   end

   assign phase_sum = SUM_W'(phase_base) + SUM_W'(cfg.tick_period_ms);

   // Next timer state and display action
   always_comb begin
      cycling_in     = cycling_now;
      idle_in        = idle_base;
      phase_timer_in = phase_timer_ff;
      phase_idx_in   = phase_idx_ff;
      phases_in      = phases_ff;
      action_o       = code_valid ? rvkc_pkg::ACT_SHOW : rvkc_pkg::ACT_NONE;
      if (!cycling_now) begin
         idle_in = idle_sat;
         if (idle_sat > rvkc_pkg::TIMER_W'(cfg.idle_threshold_ms)) begin
            cycling_in     = 1'b1;
            phase_timer_in = rvkc_pkg::TIMER_W'(cfg.phase_length_ms);
            phase_idx_in   = PHASE_RESET_IDX;
            phases_in      = '0;
         end
      end else begin
         if (phases_ff > rvkc_pkg::PHASES_W'(cfg.phase_limit)) begin
            action_o = rvkc_pkg::ACT_OFF;
         end else if (phase_timer_ff >= rvkc_pkg::TIMER_W'(cfg.phase_length_ms)) begin
            case (phase_idx_ff)
               rvkc_pkg::PHASE_LOGO:  action_o = rvkc_pkg::ACT_LOGO;
               rvkc_pkg::PHASE_STATE: action_o = rvkc_pkg::ACT_SHOW;
               default:               action_o = rvkc_pkg::ACT_OFF;
            endcase
            phase_idx_in = phase_idx_ff + 2'd1;
            if (phases_ff != rvkc_pkg::PHASES_MAX) begin
               phases_in = phases_ff + rvkc_pkg::PHASES_W'(1);
            end
         end
         if (phase_sum > SUM_W'(rvkc_pkg::TIMER_MAX)) begin
            phase_timer_in = rvkc_pkg::TIMER_MAX;
         end else begin
            phase_timer_in = phase_sum[rvkc_pkg::TIMER_W-1:0];
         end
      end
   end

   // Timer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cycling_ff     <= 1'b0;
         idle_ff        <= '0;
         phase_timer_ff <= '0;
         phase_idx_ff   <= '0;
         phases_ff      <= '0;
      end else if (fire) begin
         cycling_ff     <= cycling_in;
         idle_ff        <= idle_in;
         phase_timer_ff <= phase_timer_in;
         phase_idx_ff   <= phase_idx_in;
         phases_ff      <= phases_in;
      end
   end

   a_code_shows: assert property (@(posedge clock) disable iff (reset)
      fire && code_valid |-> action_o == rvkc_pkg::ACT_SHOW)
      else $error("code did not wake the display");

   a_quiet_idle: assert property (@(posedge clock) disable iff (reset)
      fire && !code_valid && !cycling_ff |-> action_o == rvkc_pkg::ACT_NONE)
      else $error("display action while not cycling");

   a_timer_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(idle_ff) && $stable(cycling_ff) && $stable(phases_ff))
      else $error("timers moved without a request");

endmodule

`default_nettype wire

@@ hdl/remote_volume_knob_controller_unit.sv @@
// ----------------------------------------------------------------------------
// remote_volume_knob_controller_unit: remote-controlled volume knob top level
// Input register, command and burn-in logic, result register; holds the
// configuration registers and the stream handshakes.
// ----------------------------------------------------------------------------
// Flow: an accepted request waits in the input register and loads the result
//   register once the result slot is free or being taken; rsp_ then presents it.
// Throughput: one request per cycle while results are taken; the input and result
//   registers each hold one item, so req_tready stays high while results are taken.
// Reset: synchronous; configuration returns to its defaults, power, mute,
//   volume and all timers clear, both registers empty.
`default_nettype none

module remote_volume_knob_controller_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request stream
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic [31:0]                     req_tdata,  // [31:0] ir_code
   input  wire logic                            req_tuser,  // [0] code_valid
   // result stream
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [0] move_valid, [1] move_clockwise, [15:2] move_steps,
   // [17:16] display_action, [19:18] display_kind, [25:20] volume_level,
   // [26] is_on, [27] is_silenced, [31:28] zero
   output      logic [31:0]                     rsp_tdata,
   // configuration writes
   input  wire logic                            csr_we,
   input  wire logic [rvkc_pkg::CSR_AW-1:0]     csr_addr,
   input  wire logic [rvkc_pkg::CSR_DW-1:0]     csr_wdata
);

   rvkc_pkg::cfg_type      cfg_ff;
   logic                   in_valid_ff;
   logic [31:0]            in_code_ff;
   logic                   in_flag_ff;
   logic                   out_valid_ff;
   logic [31:0]            out_data_ff, out_data_in;
   logic                   fire;
   rvkc_pkg::move_type     move;
   rvkc_pkg::status_type   status;
   rvkc_pkg::action_type   action;

   // Handshake: work the held request when the result slot frees up
   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= rvkc_pkg::CFG_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            rvkc_pkg::CSR_TICK_PERIOD: cfg_ff.tick_period_ms    <= csr_wdata[9:0];
            rvkc_pkg::CSR_IDLE_THRESH: cfg_ff.idle_threshold_ms <= csr_wdata;
            rvkc_pkg::CSR_PHASE_LEN:   cfg_ff.phase_length_ms   <= csr_wdata;
            rvkc_pkg::CSR_PHASE_LIMIT: cfg_ff.phase_limit       <= csr_wdata[9:0];
            rvkc_pkg::CSR_VOL_CEILING:
               cfg_ff.volume_ceiling <= csr_wdata[rvkc_pkg::VOL_W-1:0];
            rvkc_pkg::CSR_POWER_DIVS:
               cfg_ff.power_divisions <= csr_wdata[rvkc_pkg::VOL_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_code_ff <= req_tdata;
         in_flag_ff <= req_tuser;
      end
   end

   rvkc_cmd u_cmd (
      .clock           (clock),
      .reset           (reset),
      .fire            (fire),
      .code_valid      (in_flag_ff),
      .ir_code         (in_code_ff),
      .volume_ceiling  (cfg_ff.volume_ceiling),
      .power_divisions (cfg_ff.power_divisions),
      .move_o          (move),
      .status_o        (status)
   );

   rvkc_burnin u_burnin (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .code_valid (in_flag_ff),
      .cfg        (cfg_ff),
      .action_o   (action)
   );

   // Result packing
   assign out_data_in = {4'b0000, status.muted, status.powered, status.volume,
                         status.kind, action, move.steps, move.clockwise, move.valid};

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_data_ff <= out_data_in;
      end
   end

   a_rsp_no_move: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_data_ff[0] |-> out_data_ff[15:1] == '0)
      else $error("result carries steps without a move");

   a_rsp_off_kind: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_data_ff[26] |-> out_data_ff[19:18] == rvkc_pkg::KIND_OFF)
      else $error("display kind not off while powered down");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> in_valid_ff)
      else $error("accepted request lost from input register");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for the remote volume knob controller
// Sends loop ticks, with or without a remote code, on the request stream
// and checks every result against a cycle-free model of the knob. The model
// covers power, mute and volume, stepper moves and display burn-in cycling.
// Register settings change between phases while the unit is idle. Both
// stream sides pause at random.
// ----------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int QUIET_CAP   = 250;

   // One loop tick as sent on the request stream
   typedef struct packed {
      logic        code_valid;
      logic [31:0] ir_code;
   } tick_item_type;

   // Knob result as carried on the result stream
   typedef struct packed {
      logic                         move_valid;
      logic                         clockwise;
      logic [rvkc_pkg::STEPS_W-1:0] steps;
      rvkc_pkg::action_type         action;
      rvkc_pkg::kind_type           kind;
      logic [rvkc_pkg::VOL_W-1:0]   volume;
      logic                         powered;
      logic                         silenced;
   } knob_status_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [31:0]                   req_tdata = '0;   // [31:0] ir_code
   logic                          req_tuser = 1'b0; // [0] code_valid
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [31:0]                   rsp_tdata;        // move, display and knob state fields
   logic                          csr_we = 1'b0;
   logic [rvkc_pkg::CSR_AW-1:0]   csr_addr = '0;
   logic [rvkc_pkg::CSR_DW-1:0]   csr_wdata = '0;

   tick_item_type   tick_queue[$];
   tick_item_type   tick_on_bus;
   knob_status_type expected_status[$];
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   int              queued_ticks = 0;
   int              mismatch_count = 0;
   int              cycle_count = 0;

   logic [31:0] known_codes[7] = '{rvkc_pkg::CODE_VOL_UP, rvkc_pkg::CODE_VOL_DOWN,
                                   rvkc_pkg::CODE_MUTE, rvkc_pkg::CODE_POWER,
                                   rvkc_pkg::CODE_RAW_UP, rvkc_pkg::CODE_RAW_DOWN,
                                   rvkc_pkg::CODE_RESET};

   // Model state of the knob and its register copy
   rvkc_pkg::cfg_type          knob_cfg = rvkc_pkg::CFG_RESET;
   logic                       knob_on = 1'b0;
   logic                       knob_muted = 1'b0;
   logic [rvkc_pkg::VOL_W-1:0] knob_volume = '0;
   logic                       burn_active = 1'b0;
   int unsigned                idle_ms = 0;
   int unsigned                phase_ms = 0;
   logic [1:0]                 phase_idx = '0;
   int unsigned                phase_count = 0;

   remote_volume_knob_controller_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int unsigned clamp_sum(input int unsigned a, input int unsigned b,
                                             input int unsigned limit);
      int unsigned s;
      s = a + b;
      return (s > limit) ? limit : s;
   endfunction

   function automatic logic [rvkc_pkg::STEPS_W-1:0] motor_steps(input int unsigned divisions);
      return rvkc_pkg::STEPS_W'(clamp_sum(divisions * rvkc_pkg::STEPS_PER_DIVISION, 0,
                                          rvkc_pkg::STEPS_MAX));
   endfunction

   // Advance the knob model by one tick and return the result it produces
   function automatic knob_status_type advance_knob(input tick_item_type t);
      knob_status_type s;
      s = '0;
      s.action = rvkc_pkg::ACT_NONE;
      if (t.code_valid) begin
         case (t.ir_code)
            rvkc_pkg::CODE_VOL_UP: begin
               if (knob_on && !knob_muted && knob_volume < knob_cfg.volume_ceiling) begin
                  s.move_valid = 1'b1;
                  s.steps = motor_steps(1);
                  knob_volume = knob_volume + 1'b1;
               end
            end
            rvkc_pkg::CODE_VOL_DOWN: begin
               if (knob_on && !knob_muted && knob_volume > 0) begin
                  s.move_valid = 1'b1;
                  s.clockwise = 1'b1;
                  s.steps = motor_steps(1);
                  knob_volume = knob_volume - 1'b1;
               end
            end
            rvkc_pkg::CODE_MUTE: begin
               if (knob_on && knob_volume != 0) begin
                  s.move_valid = 1'b1;
                  s.clockwise = !knob_muted;
                  s.steps = motor_steps(knob_volume);
                  knob_muted = !knob_muted;
               end
            end
            rvkc_pkg::CODE_POWER: begin
               s.move_valid = 1'b1;
               s.clockwise = knob_on;
               s.steps = motor_steps(knob_cfg.power_divisions + (knob_muted ? 0 : knob_volume));
               knob_on = !knob_on;
            end
            rvkc_pkg::CODE_RAW_UP: begin
               s.move_valid = 1'b1;
               s.steps = motor_steps(1);
            end
            rvkc_pkg::CODE_RAW_DOWN: begin
               s.move_valid = 1'b1;
               s.clockwise = 1'b1;
               s.steps = motor_steps(1);
            end
            rvkc_pkg::CODE_RESET: begin
               knob_on = 1'b0;
               knob_muted = 1'b0;
               knob_volume = '0;
            end
            default: ;
         endcase
         // any code wakes the display and restarts the idle count
         burn_active = 1'b0;
         idle_ms = 0;
         s.action = rvkc_pkg::ACT_SHOW;
      end

      // burn-in protection timers
      if (!burn_active) begin
         idle_ms = clamp_sum(idle_ms, knob_cfg.tick_period_ms, rvkc_pkg::TIMER_MAX);
         if (idle_ms > knob_cfg.idle_threshold_ms) begin
            burn_active = 1'b1;
            phase_ms = knob_cfg.phase_length_ms;
            phase_idx = rvkc_pkg::PHASE_LOGO;
            phase_count = 0;
         end
      end else begin
         if (phase_count > knob_cfg.phase_limit) begin
            s.action = rvkc_pkg::ACT_OFF;
         end else if (phase_ms >= knob_cfg.phase_length_ms) begin
            case (phase_idx)
               rvkc_pkg::PHASE_LOGO:  s.action = rvkc_pkg::ACT_LOGO;
               rvkc_pkg::PHASE_STATE: s.action = rvkc_pkg::ACT_SHOW;
               default:               s.action = rvkc_pkg::ACT_OFF;
            endcase
            phase_idx = phase_idx + 1'b1;
            phase_ms = 0;
            phase_count = clamp_sum(phase_count, 1, rvkc_pkg::PHASES_MAX);
         end
         phase_ms = clamp_sum(phase_ms, knob_cfg.tick_period_ms, rvkc_pkg::TIMER_MAX);
      end

      if (!knob_on) s.kind = rvkc_pkg::KIND_OFF;
      else if (knob_muted || knob_volume == 0) s.kind = rvkc_pkg::KIND_ZERO;
      else if (knob_volume == knob_cfg.volume_ceiling) s.kind = rvkc_pkg::KIND_MAX;
      else s.kind = rvkc_pkg::KIND_NUM;
      s.volume = knob_volume;
      s.powered = knob_on;
      s.silenced = knob_muted;
      return s;
   endfunction

   task automatic queue_tick(input logic code_valid, input logic [31:0] code);
      tick_queue.push_back('{code_valid: code_valid, ir_code: code});
      queued_ticks++;
   endtask

   task automatic queue_code(input logic [31:0] code);
      queue_tick(1'b1, code);
   endtask

   // Ticks without a code; the code bits still toggle
   task automatic queue_quiet(input int n);
      repeat (n) queue_tick(1'b0, $urandom());
   endtask

   // Mostly valid commands, some unknown codes and near misses
   function automatic logic [31:0] pick_command();
      int r;
      r = $urandom_range(0, 99);
      if (r < 28) return rvkc_pkg::CODE_VOL_UP;
      if (r < 44) return rvkc_pkg::CODE_VOL_DOWN;
      if (r < 54) return rvkc_pkg::CODE_MUTE;
      if (r < 64) return rvkc_pkg::CODE_POWER;
      if (r < 70) return rvkc_pkg::CODE_RAW_UP;
      if (r < 76) return rvkc_pkg::CODE_RAW_DOWN;
      if (r < 80) return rvkc_pkg::CODE_RESET;
      if (r < 90) return $urandom();
      return known_codes[$urandom_range(0, 6)] ^ (32'd1 << $urandom_range(0, 31));
   endfunction

   // Register write; the model copy follows at the write edge
   task automatic write_knob_reg(input rvkc_pkg::csr_idx_type idx,
                                 input logic [rvkc_pkg::CSR_DW-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         rvkc_pkg::CSR_TICK_PERIOD: knob_cfg.tick_period_ms = value[9:0];
         rvkc_pkg::CSR_IDLE_THRESH: knob_cfg.idle_threshold_ms = value;
         rvkc_pkg::CSR_PHASE_LEN:   knob_cfg.phase_length_ms = value;
         rvkc_pkg::CSR_PHASE_LIMIT: knob_cfg.phase_limit = value[9:0];
         rvkc_pkg::CSR_VOL_CEILING: knob_cfg.volume_ceiling = value[rvkc_pkg::VOL_W-1:0];
         rvkc_pkg::CSR_POWER_DIVS:  knob_cfg.power_divisions = value[rvkc_pkg::VOL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input int tick, input int thresh, input int plen,
                                input int limit, input int maxv, input int pdiv);
      write_knob_reg(rvkc_pkg::CSR_TICK_PERIOD, rvkc_pkg::CSR_DW'(tick));
      write_knob_reg(rvkc_pkg::CSR_IDLE_THRESH, rvkc_pkg::CSR_DW'(thresh));
      write_knob_reg(rvkc_pkg::CSR_PHASE_LEN, rvkc_pkg::CSR_DW'(plen));
      write_knob_reg(rvkc_pkg::CSR_PHASE_LIMIT, rvkc_pkg::CSR_DW'(limit));
      write_knob_reg(rvkc_pkg::CSR_VOL_CEILING, rvkc_pkg::CSR_DW'(maxv));
      write_knob_reg(rvkc_pkg::CSR_POWER_DIVS, rvkc_pkg::CSR_DW'(pdiv));
   endtask

   task automatic wait_drained();
      while (tick_queue.size() != 0 || req_tvalid || expected_status.size() != 0)
         @(negedge clock);
   endtask

   function automatic void check_field(input string name, input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Request driver: holds a request until taken, pauses at random between them
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) expected_status.push_back(advance_knob(tick_on_bus));
         if (tick_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            tick_on_bus = tick_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= tick_on_bus.code_valid;
            req_tdata <= tick_on_bus.ir_code;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result monitor with random back-pressure
   always @(posedge clock) begin : result_monitor
      knob_status_type want;
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_status.size() == 0) begin
            $error("result with no request pending: %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = expected_status.pop_front();
            check_field("move_valid", want.move_valid, rsp_tdata[0]);
            check_field("move_clockwise", want.clockwise, rsp_tdata[1]);
            check_field("move_steps", want.steps, rsp_tdata[15:2]);
            check_field("display_action", want.action, rsp_tdata[17:16]);
            check_field("display_kind", want.kind, rsp_tdata[19:18]);
            check_field("volume_level", want.volume, rsp_tdata[25:20]);
            check_field("is_on", want.powered, rsp_tdata[26]);
            check_field("is_silenced", want.silenced, rsp_tdata[27]);
            check_field("pad", 0, rsp_tdata[31:28]);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   initial begin
      int reach;
      int span;
      int tick;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int seg = 0; seg < 9; seg++) begin
         // pause mix: sender light and receiver heavy, then reversed, then none
         if (seg < 3) begin
            send_idle_pct = 15;
            recv_idle_pct = 58;
         end else if (seg < 6) begin
            send_idle_pct = 58;
            recv_idle_pct = 15;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         case (seg)
            0: ; // reset defaults
            1: apply_setting(1000, 0, 1, 0, 1, 0);
            2: apply_setting(1, 3, 2, 5, 63, 63);
            3: apply_setting(1000, 65535, 65535, 1023, 20, 10);
            4: apply_setting(700, 2000, 0, 3, 40, 33);
            5: apply_setting(1000, 100, 500, 0, 5, 1);
            default: begin
               tick = $urandom_range(1, 1000);
               apply_setting(tick, $urandom_range(0, (tick * 20 > 65535) ? 65535 : tick * 20),
                             $urandom_range(1, (tick * 8 > 65535) ? 65535 : tick * 8),
                             $urandom_range(0, 12), $urandom_range(1, 63),
                             $urandom_range(0, 63));
            end
         endcase

         queued_ticks = 0;
         if (seg == 0) begin
            // ignored while off, power on, ignored at zero volume
            queue_code(rvkc_pkg::CODE_VOL_UP);
            queue_code(rvkc_pkg::CODE_MUTE);
            queue_code(rvkc_pkg::CODE_POWER);
            queue_code(rvkc_pkg::CODE_VOL_DOWN);
            queue_code(rvkc_pkg::CODE_MUTE);
            repeat (3) queue_code(rvkc_pkg::CODE_VOL_UP);
            // mute, volume blocked while muted, power cycle while muted
            queue_code(rvkc_pkg::CODE_MUTE);
            queue_code(rvkc_pkg::CODE_VOL_UP);
            queue_code(rvkc_pkg::CODE_POWER);
            queue_code(rvkc_pkg::CODE_POWER);
            queue_code(rvkc_pkg::CODE_MUTE);
            queue_code(rvkc_pkg::CODE_RAW_UP);
            queue_code(rvkc_pkg::CODE_RAW_DOWN);
            // unknown codes and a known code without its valid flag
            queue_code(32'hFFFF_FFFF);
            queue_code(32'h0000_0000);
            queue_tick(1'b0, rvkc_pkg::CODE_POWER);
            queue_code(rvkc_pkg::CODE_RESET);
         end
         if (seg == 5) queue_quiet(200); // phase timer saturates after the limit

         reach = knob_cfg.idle_threshold_ms / knob_cfg.tick_period_ms + 2;
         span = reach + 6 * (knob_cfg.phase_length_ms / knob_cfg.tick_period_ms + 1);
         if (span > QUIET_CAP) span = QUIET_CAP;
         while (queued_ticks < 200) begin
            repeat ($urandom_range(1, 6)) queue_code(pick_command());
            if ($urandom_range(0, 1)) queue_quiet($urandom_range(0, 3));
            else queue_quiet($urandom_range(0, span));
         end

         if (seg == 2) begin
            // climb to the top, past max, then power moves of 126 divisions
            queue_code(rvkc_pkg::CODE_RESET);
            queue_code(rvkc_pkg::CODE_POWER);
            repeat (65) queue_code(rvkc_pkg::CODE_VOL_UP);
            queue_code(rvkc_pkg::CODE_POWER);
            queue_code(rvkc_pkg::CODE_POWER);
         end

         wait_drained();
         repeat (4) @(posedge clock);
      end

      wait_drained();
      repeat (6) @(posedge clock);
      if (mismatch_count == 0 && expected_status.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
